@@ rtl/hbd_pkg.sv @@
`default_nettype none

package hbd_pkg;

  typedef logic [3:0] phase_t;
  typedef logic [1:0] kind_t;

  // framing phases
  localparam phase_t PH_IDLE     = 4'd0;
  localparam phase_t PH_CL_BODY  = 4'd1;
  localparam phase_t PH_SIZE     = 4'd2;
  localparam phase_t PH_SIZE_LF  = 4'd3;
  localparam phase_t PH_DATA     = 4'd4;
  localparam phase_t PH_DATA_CR  = 4'd5;
  localparam phase_t PH_DATA_LF  = 4'd6;
  localparam phase_t PH_FINAL_CR = 4'd7;
  localparam phase_t PH_FINAL_LF = 4'd8;
  localparam phase_t PH_DONE     = 4'd9;
  localparam phase_t PH_ERROR    = 4'd10;

  // result kinds
  localparam kind_t KIND_NONE = 2'd0;
  localparam kind_t KIND_BYTE = 2'd1;
  localparam kind_t KIND_END  = 2'd2;
  localparam kind_t KIND_ERR  = 2'd3;

  // action codes
  localparam logic ACT_START = 1'b0;
  localparam logic ACT_BYTE  = 1'b1;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_F  = 8'h66;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_F  = 8'h46;
  localparam logic [3:0] HEX_TEN  = 4'd10;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } hex_t;

  // hex digit decode, ok low for any other byte
  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    h.ok    = 1'b1;
    h.value = 4'd0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      h.value = 4'(c - CH_ZERO);
    end else if (c >= CH_LO_A && c <= CH_LO_F) begin
      h.value = 4'(c - CH_LO_A) + HEX_TEN;
    end else if (c >= CH_UP_A && c <= CH_UP_F) begin
      h.value = 4'(c - CH_UP_A) + HEX_TEN;
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage

`default_nettype wire

@@ rtl/hbd_if.sv @@
`default_nettype none

// stream side: start items and stream bytes
interface hbd_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic        chunked;
  logic [31:0] body_length;
  logic [7:0]  data_byte;

  modport source (output valid, action, chunked, body_length, data_byte, input ready);
  modport sink   (input valid, action, chunked, body_length, data_byte, output ready);
endinterface

// body side: one result item per input item
interface hbd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] body_byte;
  logic       last;

  modport source (output valid, kind, body_byte, last, input ready);
  modport sink   (input valid, kind, body_byte, last, output ready);
endinterface

`default_nettype wire

@@ rtl/http_body_deframer.sv @@
`default_nettype none

// channel  dir  fields                                   accepted when
// stream   in   action, chunked, body_length, data_byte  valid & ready
// body     out  kind, body_byte, last                    valid & ready
//
// one item per cycle unless the body side stalls: each input item is decoded against the framing state
// and its result lands in the output register on the edge that accepts it
// the critical path is the remaining-count decrement / size-limit compare
// ready stays high while the output register is empty or being drained,
// so a stalled body side holds at most one result and stalls the stream
// rst is synchronous: phase idle, counters cleared, output register empty

module http_body_deframer #(
  parameter int SIZE_BITS = 32
) (
  input wire logic  clk,
  input wire logic  rst,
  hbd_in_if.sink    stream,
  hbd_out_if.source body
);
  import hbd_pkg::*;

  // counter must hold a 32-bit content length or a full chunk size
  localparam int CNT_W = (SIZE_BITS > 32) ? SIZE_BITS : 32;
  // largest size that may still take one more hex digit
  localparam logic [CNT_W-1:0] SIZE_LIMIT =
    CNT_W'({(SIZE_BITS-4){1'b1}});

  phase_t           phase, phase_next;
  logic [CNT_W-1:0] remaining, remaining_next;
  logic             size_seen_digit, size_seen_digit_next;

  // output register
  logic       out_valid;
  kind_t      out_kind, kind_next;
  logic [7:0] out_byte, byte_next;
  logic       out_last, last_next;

  logic             accept;
  logic [CNT_W-1:0] rem_dec;
  hex_t             hex;
  logic             bad;

  assign stream.ready = !out_valid || body.ready;
  assign accept       = stream.valid && stream.ready;

  assign rem_dec = remaining - CNT_W'(1);
  assign hex     = hex_decode(stream.data_byte);

  always_comb begin
    phase_next           = phase;
    remaining_next       = remaining;
    size_seen_digit_next = size_seen_digit;
    kind_next            = KIND_NONE;
    byte_next            = 8'd0;
    last_next            = 1'b0;
    bad                  = 1'b0;

    if (stream.action == ACT_START) begin
      size_seen_digit_next = 1'b0;
      remaining_next       = '0;
      if (stream.chunked) begin
        phase_next = PH_SIZE;
      end else if (stream.body_length == 32'd0) begin
        // empty body finishes on the start itself
        phase_next = PH_DONE;
        kind_next  = KIND_END;
        last_next  = 1'b1;
      end else begin
        phase_next     = PH_CL_BODY;
        remaining_next = CNT_W'(stream.body_length);
      end
    end else begin
      case (phase)
        PH_CL_BODY: begin
          remaining_next = rem_dec;
          kind_next      = KIND_BYTE;
          byte_next      = stream.data_byte;
          if (rem_dec == '0) begin
            phase_next = PH_DONE;
            last_next  = 1'b1;
          end
        end
        PH_SIZE: begin
          if (stream.data_byte == CH_CR) begin
            // a size line with no digits is malformed
            if (!size_seen_digit) bad = 1'b1;
            else phase_next = PH_SIZE_LF;
          end else if (!hex.ok || remaining > SIZE_LIMIT) begin
            // extensions, junk or size overflow
            bad = 1'b1;
          end else begin
            remaining_next       = {remaining[CNT_W-5:0], hex.value};
            size_seen_digit_next = 1'b1;
          end
        end
        PH_SIZE_LF: begin
          if (stream.data_byte != CH_LF) bad = 1'b1;
          else if (remaining == '0) phase_next = PH_FINAL_CR;
          else phase_next = PH_DATA;
        end
        PH_DATA: begin
          remaining_next = rem_dec;
          kind_next      = KIND_BYTE;
          byte_next      = stream.data_byte;
          if (rem_dec == '0) phase_next = PH_DATA_CR;
        end
        PH_DATA_CR: begin
          if (stream.data_byte != CH_CR) bad = 1'b1;
          else phase_next = PH_DATA_LF;
        end
        PH_DATA_LF: begin
          if (stream.data_byte != CH_LF) begin
            bad = 1'b1;
          end else begin
            phase_next           = PH_SIZE;
            remaining_next       = '0;
            size_seen_digit_next = 1'b0;
          end
        end
        PH_FINAL_CR: begin
          if (stream.data_byte != CH_CR) bad = 1'b1;
          else phase_next = PH_FINAL_LF;
        end
        PH_FINAL_LF: begin
          if (stream.data_byte != CH_LF) begin
            bad = 1'b1;
          end else begin
            phase_next = PH_DONE;
            kind_next  = KIND_END;
            last_next  = 1'b1;
          end
        end
        PH_ERROR: begin
          // sticky until the next start
          bad = 1'b1;
        end
        default: begin
          // idle or done: trailing bytes are dropped unchecked
        end
      endcase

      if (bad) begin
        phase_next = PH_ERROR;
        kind_next  = KIND_ERR;
        byte_next  = 8'd0;
        last_next  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      remaining       <= '0;
      size_seen_digit <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (accept) begin
        phase           <= phase_next;
        remaining       <= remaining_next;
        size_seen_digit <= size_seen_digit_next;
        out_valid       <= 1'b1;
      end else if (body.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload of the output register, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      out_kind <= kind_next;
      out_byte <= byte_next;
      out_last <= last_next;
    end
  end

  assign body.valid     = out_valid;
  assign body.kind      = out_kind;
  assign body.body_byte = out_byte;
  assign body.last      = out_last;

endmodule

`default_nettype wire

@@ rtl/hbd_checker.sv @@
`default_nettype none

module hbd_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        action,
  input wire logic        chunked,
  input wire logic [31:0] body_length,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  kind,
  input wire logic [7:0]  body_byte,
  input wire logic        last
);
  import hbd_pkg::*;

  logic in_acc;
  logic out_show;

  assign in_acc   = in_valid && in_ready;
  assign out_show = out_valid;

  // every accepted item has its result on show in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> out_valid)
    else $error("no result after an accepted item");

  // an empty content-length body ends on the start item
  a_empty_body_end: assert property (@(posedge clk) disable iff (rst)
    (in_acc && action == ACT_START && !chunked && body_length == 32'd0)
      |=> (kind == KIND_END && last))
    else $error("empty body did not end at once");

  // ending and error results carry last, empty results never do, body bytes may
  a_last_kind: assert property (@(posedge clk) disable iff (rst)
    out_show |-> (last == (kind == KIND_END || kind == KIND_ERR
                           || (kind == KIND_BYTE && last))))
    else $error("last flag does not match kind");

  // data only on body-byte results
  a_byte_zero: assert property (@(posedge clk) disable iff (rst)
    (out_show && kind != KIND_BYTE) |-> body_byte == 8'd0)
    else $error("data byte on a non-data result");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(kind)
                                   && $stable(body_byte) && $stable(last)))
    else $error("stalled result changed");

endmodule

bind http_body_deframer hbd_checker u_hbd_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (stream.valid),
  .in_ready    (stream.ready),
  .action      (stream.action),
  .chunked     (stream.chunked),
  .body_length (stream.body_length),
  .out_valid   (body.valid),
  .out_ready   (body.ready),
  .kind        (body.kind),
  .body_byte   (body.body_byte),
  .last        (body.last)
);

`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import hbd_pkg::*;

  // chunk sizes are checked against this width, so the dut gets the same value
  localparam int SIZE_BITS = 32;
  localparam logic [63:0] SIZE_CAP = (64'hFFFF_FFFF_FFFF_FFFF >> (64 - SIZE_BITS)) >> 4;

  localparam int ITEMS_PER_PHASE = 500;  // three random phases, ~1550 items in all
  localparam int HOLD_AT         = 700;  // body items seen before the long hold-off
  localparam int HOLD_CYCLES     = 300;
  localparam int STALL_LIMIT     = 4000; // cycles with no handshake on either side
  localparam int DRAIN_CYCLES    = 16;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] body_byte;
    logic       last;
  } body_res_t;

  // one stream item, plus an optional expectation typed straight into the table
  typedef struct packed {
    logic       action;
    logic       chunked;
    logic [31:0] body_length;
    logic [7:0] data_byte;
    logic       has_fixed;
    body_res_t  fixed_res;
  } stream_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  hbd_in_if  stream_if ();
  hbd_out_if body_if ();

  http_body_deframer #(.SIZE_BITS(SIZE_BITS)) dut (
    .clk    (clk),
    .rst    (rst),
    .stream (stream_if),
    .body   (body_if)
  );

  // items waiting to be offered, and body items the predictor has worked out
  stream_item_t stim_q [$];
  body_res_t    body_expect_q [$];
  logic [7:0]   frame_q [$];   // scratch for building one chunked message

  int idle_pct  = 0;
  int stall_pct = 0;
  int mismatches = 0;
  int results_seen = 0;
  int gen_count = 0;

  // predictor state: framing phase, bytes left or size being built, digit seen
  phase_t      fr_phase = PH_IDLE;
  logic [63:0] fr_left  = 64'd0;
  logic        fr_digit = 1'b0;

  function automatic int hex_nibble(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - int'("0");
    if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
    if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
    return -1;
  endfunction

  // advance the framing state by one stream item and return its body item
  function automatic body_res_t deframe(input stream_item_t s);
    body_res_t r;
    int        hv;
    logic      bad;
    r   = '{KIND_NONE, 8'h00, 1'b0};
    bad = 1'b0;
    if (s.action == ACT_START) begin
      // a start clears everything, whatever came before
      fr_digit = 1'b0;
      fr_left  = 64'd0;
      if (s.chunked) begin
        fr_phase = PH_SIZE;
      end else if (s.body_length == 32'd0) begin
        fr_phase = PH_DONE;
        r.kind   = KIND_END;
        r.last   = 1'b1;
      end else begin
        fr_phase = PH_CL_BODY;
        fr_left  = {32'd0, s.body_length};
      end
      return r;
    end
    case (fr_phase)
      PH_CL_BODY: begin
        fr_left     = fr_left - 64'd1;
        r.kind      = KIND_BYTE;
        r.body_byte = s.data_byte;
        if (fr_left == 64'd0) begin
          r.last   = 1'b1;
          fr_phase = PH_DONE;
        end
      end
      PH_SIZE: begin
        if (s.data_byte == CH_CR) begin
          // an empty size line is a framing error
          if (!fr_digit) bad = 1'b1;
          else fr_phase = PH_SIZE_LF;
        end else begin
          hv = hex_nibble(s.data_byte);
          // extensions and stray characters fail here, as does a size too wide
          if (hv < 0 || fr_left > SIZE_CAP) begin
            bad = 1'b1;
          end else begin
            fr_left  = (fr_left << 4) + 64'(hv);
            fr_digit = 1'b1;
          end
        end
      end
      PH_SIZE_LF: begin
        if (s.data_byte != CH_LF) bad = 1'b1;
        else fr_phase = (fr_left == 64'd0) ? PH_FINAL_CR : PH_DATA;
      end
      PH_DATA: begin
        fr_left     = fr_left - 64'd1;
        r.kind      = KIND_BYTE;
        r.body_byte = s.data_byte;
        if (fr_left == 64'd0) fr_phase = PH_DATA_CR;
      end
      PH_DATA_CR: begin
        if (s.data_byte != CH_CR) bad = 1'b1;
        else fr_phase = PH_DATA_LF;
      end
      PH_DATA_LF: begin
        if (s.data_byte != CH_LF) begin
          bad = 1'b1;
        end else begin
          fr_phase = PH_SIZE;
          fr_left  = 64'd0;
          fr_digit = 1'b0;
        end
      end
      PH_FINAL_CR: begin
        if (s.data_byte != CH_CR) bad = 1'b1;
        else fr_phase = PH_FINAL_LF;
      end
      PH_FINAL_LF: begin
        if (s.data_byte != CH_LF) begin
          bad = 1'b1;
        end else begin
          fr_phase = PH_DONE;
          r.kind   = KIND_END;
          r.last   = 1'b1;
        end
      end
      PH_ERROR: bad = 1'b1;  // sticky until the next start
      default: ;             // idle or done: trailing bytes are ignored
    endcase
    if (bad) begin
      fr_phase = PH_ERROR;
      r        = '{KIND_ERR, 8'h00, 1'b1};
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus building
  // ---------------------------------------------------------------------------

  task automatic push_start(input logic chunked, input logic [31:0] blen);
    stim_q.push_back('{ACT_START, chunked, blen, 8'($urandom_range(255)), 1'b0, '0});
    gen_count++;
  endtask

  // trailing bytes after a message are queued without counting towards the total
  task automatic push_byte(input logic [7:0] b, input bit counted);
    stim_q.push_back('{ACT_BYTE, 1'($urandom_range(1)), 32'($urandom), b, 1'b0, '0});
    if (counted) gen_count++;
  endtask

  // hex digit in either case, picked at random
  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return CH_ZERO + 8'(n);
    if ($urandom_range(1) == 0) return CH_LO_A + 8'(n - 4'd10);
    return CH_UP_A + 8'(n - 4'd10);
  endfunction

  // size line with optional leading zeros, then cr lf
  task automatic add_size_line(input logic [63:0] v, input int pad);
    int nd;
    nd = 1;
    while (nd < 16 && (v >> (4 * nd)) != 64'd0) nd++;
    for (int i = nd + pad - 1; i >= 0; i--) begin
      frame_q.push_back(hex_char((i < nd) ? v[4 * i +: 4] : 4'd0));
    end
    frame_q.push_back(CH_CR);
    frame_q.push_back(CH_LF);
  endtask

  // bytes that tend to matter to the framing, mixed with plain random ones
  function automatic logic [7:0] noise_byte();
    case ($urandom_range(5))
      0: return CH_CR;
      1: return CH_LF;
      2: return 8'h3B;  // ';' opening a chunk extension
      3: return hex_char(4'($urandom_range(15)));
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic gen_messages(input int n_items);
    int          pick;
    int          nbytes;
    int          nchunks;
    int          csize;
    logic [31:0] blen;
    gen_count = 0;
    while (gen_count < n_items) begin
      pick = $urandom_range(99);
      if (pick < 30) begin
        // content-length body: mostly short and complete, now and then a
        // full-width length cut off by the next start
        case ($urandom_range(9))
          0: begin
            blen   = 32'd0;
            nbytes = 0;
          end
          1: begin
            blen   = 32'($urandom);
            nbytes = $urandom_range(1, 4);
          end
          default: begin
            blen   = 32'($urandom_range(1, 12));
            nbytes = int'(blen);
          end
        endcase
        push_start(1'b0, blen);
        for (int i = 0; i < nbytes; i++) push_byte(8'($urandom_range(255)), 1'b1);
        if (32'(nbytes) == blen && $urandom_range(4) == 0) begin
          for (int i = 0; i < $urandom_range(1, 2); i++) push_byte(noise_byte(), 1'b0);
        end
      end else if (pick < 85) begin
        // chunked message, well formed unless corrupted, oversized or cut short below
        frame_q.delete();
        nchunks = $urandom_range(0, 3);
        for (int c = 0; c < nchunks; c++) begin
          csize = $urandom_range(1, 12);
          add_size_line(64'(csize), ($urandom_range(4) == 0) ? $urandom_range(1, 2) : 0);
          for (int i = 0; i < csize; i++) frame_q.push_back(8'($urandom_range(255)));
          frame_q.push_back(CH_CR);
          frame_q.push_back(CH_LF);
        end
        case ($urandom_range(24))
          0: begin
            // nine digits: the last one overflows the size
            add_size_line({28'd0, 4'($urandom_range(1, 15)), 32'($urandom)}, 0);
          end
          1: begin
            // widest size that still fits, followed by a little of its data
            add_size_line({32'd0, 32'($urandom) | 32'h1000_0000}, 0);
            for (int i = 0; i < $urandom_range(1, 3); i++) begin
              frame_q.push_back(8'($urandom_range(255)));
            end
          end
          default: begin
            add_size_line(64'd0, $urandom_range(0, 2));
            frame_q.push_back(CH_CR);
            frame_q.push_back(CH_LF);
          end
        endcase
        if ($urandom_range(7) == 0) begin
          frame_q[$urandom_range(frame_q.size() - 1)] = 8'($urandom_range(255));
        end
        push_start(1'b1, 32'($urandom));
        foreach (frame_q[i]) push_byte(frame_q[i], 1'b1);
        if ($urandom_range(6) == 0) push_byte(noise_byte(), 1'b0);
      end else begin
        // noise after a start of either kind
        push_start(1'($urandom_range(1)), 32'($urandom_range(0, 6)));
        for (int i = 0; i < $urandom_range(1, 6); i++) push_byte(noise_byte(), 1'b1);
      end
    end
  endtask

  // directed rows: fixed expectations only where they are obvious,
  // everything else goes through the predictor
  localparam int N_DIRECTED = 24;
  stream_item_t directed_tbl [N_DIRECTED] = '{
    // byte before any start is ignored
    '{ACT_BYTE,  1'b0, 32'd0,          8'h00,           1'b1, '{KIND_NONE, 8'h00, 1'b0}},
    // zero content length ends on the start itself
    '{ACT_START, 1'b0, 32'd0,          8'h00,           1'b1, '{KIND_END,  8'h00, 1'b1}},
    // trailing byte after completion is ignored
    '{ACT_BYTE,  1'b1, 32'hFFFF_FFFF,  8'hFF,           1'b1, '{KIND_NONE, 8'h00, 1'b0}},
    // largest length, cut off by the next start
    '{ACT_START, 1'b0, 32'hFFFF_FFFF,  8'hFF,           1'b1, '{KIND_NONE, 8'h00, 1'b0}},
    '{ACT_BYTE,  1'b0, 32'd0,          8'hA5,           1'b0, '0},
    // two-byte body, last marked on the second
    '{ACT_START, 1'b0, 32'd2,          8'h00,           1'b1, '{KIND_NONE, 8'h00, 1'b0}},
    '{ACT_BYTE,  1'b0, 32'd0,          8'h00,           1'b0, '0},
    '{ACT_BYTE,  1'b0, 32'd0,          8'hFF,           1'b0, '0},
    // one chunk of two bytes, then the terminating chunk
    '{ACT_START, 1'b1, 32'd0,          8'h00,           1'b1, '{KIND_NONE, 8'h00, 1'b0}},
    '{ACT_BYTE,  1'b0, 32'd0,          CH_ZERO + 8'd2,  1'b0, '0},
    '{ACT_BYTE,  1'b0, 32'd0,          CH_CR,           1'b0, '0},
    '{ACT_BYTE,  1'b0, 32'd0,          CH_LF,           1'b0, '0},
    '{ACT_BYTE,  1'b0, 32'd0,          8'h00,           1'b0, '0},
    '{ACT_BYTE,  1'b0, 32'd0,          8'hFF,           1'b0, '0},
    '{ACT_BYTE,  1'b0, 32'd0,          CH_CR,           1'b0, '0},
    '{ACT_BYTE,  1'b0, 32'd0,          CH_LF,           1'b0, '0},
    '{ACT_BYTE,  1'b0, 32'd0,          CH_ZERO,         1'b0, '0},
    '{ACT_BYTE,  1'b0, 32'd0,          CH_CR,           1'b0, '0},
    '{ACT_BYTE,  1'b0, 32'd0,          CH_LF,           1'b0, '0},
    '{ACT_BYTE,  1'b0, 32'd0,          CH_CR,           1'b0, '0},
    '{ACT_BYTE,  1'b0, 32'd0,          CH_LF,           1'b1, '{KIND_END,  8'h00, 1'b1}},
    // empty size line, then the error sticks
    '{ACT_START, 1'b1, 32'd0,          8'h00,           1'b1, '{KIND_NONE, 8'h00, 1'b0}},
    '{ACT_BYTE,  1'b0, 32'd0,          CH_CR,           1'b1, '{KIND_ERR,  8'h00, 1'b1}},
    '{ACT_BYTE,  1'b0, 32'd0,          CH_LO_A,         1'b1, '{KIND_ERR,  8'h00, 1'b1}}
  };

  // ---------------------------------------------------------------------------
  // stream side: offer the next queued item, idling now and then
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      stream_if.valid <= 1'b0;
    end else if (!stream_if.valid || stream_if.ready) begin
      // slot is free: either nothing on offer or the current item just went in
      if (stim_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
        stream_if.valid       <= 1'b1;
        stream_if.action      <= stim_q[0].action;
        stream_if.chunked     <= stim_q[0].chunked;
        stream_if.body_length <= stim_q[0].body_length;
        stream_if.data_byte   <= stim_q[0].data_byte;
        void'(stim_q.pop_front());
      end else begin
        stream_if.valid <= 1'b0;
      end
    end
  end

  // predictor: works on every accepted stream item, straight off the bus
  stream_item_t acc_item;
  body_res_t    pred_res;
  stream_item_t fixed_q [$];  // table expectations, in offer order
  always @(posedge clk) begin
    if (!rst && stream_if.valid && stream_if.ready) begin
      acc_item = '{stream_if.action, stream_if.chunked, stream_if.body_length,
                   stream_if.data_byte, 1'b0, '0};
      pred_res = deframe(acc_item);
      // rows of the directed table carry their own expectation
      if (fixed_q.size() != 0) begin
        acc_item = fixed_q.pop_front();
        if (acc_item.has_fixed) pred_res = acc_item.fixed_res;
      end
      body_expect_q.push_back(pred_res);
    end
  end

  // ---------------------------------------------------------------------------
  // body side: stall at random, plus one long hold-off so the stream backs up
  // ---------------------------------------------------------------------------
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  always @(posedge clk) begin
    if (rst) begin
      body_if.ready <= 1'b0;
    end else begin
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
      end else if (!hold_done && results_seen >= HOLD_AT) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      body_if.ready <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
    end
  end

  // checker: each body item against the oldest expectation
  body_res_t seen_res;
  body_res_t want_res;
  always @(posedge clk) begin
    if (!rst && body_if.valid && body_if.ready) begin
      seen_res     = '{body_if.kind, body_if.body_byte, body_if.last};
      results_seen = results_seen + 1;
      if (body_expect_q.size() == 0) begin
        mismatches = mismatches + 1;
        if (mismatches <= 10) begin
          $display("body item with nothing expected: kind %0d byte %02h last %0b",
                   seen_res.kind, seen_res.body_byte, seen_res.last);
        end
      end else begin
        want_res = body_expect_q.pop_front();
        if (seen_res.kind !== want_res.kind || seen_res.body_byte !== want_res.body_byte ||
            seen_res.last !== want_res.last) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10) begin
            $display("body item %0d: expected %0d/%02h/%0b, got %0d/%02h/%0b",
                     results_seen, want_res.kind, want_res.body_byte, want_res.last,
                     seen_res.kind, seen_res.body_byte, seen_res.last);
          end
        end
      end
    end
  end

  // watchdog: too long without a handshake on either side ends the run
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if ((stream_if.valid && stream_if.ready) || (body_if.valid && body_if.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    stream_if.valid       = 1'b0;
    stream_if.action      = ACT_START;
    stream_if.chunked     = 1'b0;
    stream_if.body_length = 32'd0;
    stream_if.data_byte   = 8'h00;
    body_if.ready         = 1'b0;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed table first, under the first idling setting
    idle_pct  = 32;
    stall_pct = 48;
    for (int i = 0; i < N_DIRECTED; i++) begin
      stim_q.push_back(directed_tbl[i]);
      fixed_q.push_back(directed_tbl[i]);
    end
    while (stim_q.size() != 0 || fixed_q.size() != 0) @(posedge clk);

    // random phases: receiver stalls more, then sender idles more, then no idling at all
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          idle_pct  = 32;
          stall_pct = 48;
        end
        1: begin
          idle_pct  = 48;
          stall_pct = 32;
        end
        default: begin
          idle_pct  = 0;
          stall_pct = 0;
        end
      endcase
      gen_messages(ITEMS_PER_PHASE);
      while (stim_q.size() != 0) @(posedge clk);
    end

    // last item accepted, every expectation met, then a short drain
    while (stream_if.valid) @(posedge clk);
    while (body_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && body_expect_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
